>>> src/smf_pkg.sv
// Shared types and constants for the sliding-window median filter.
// No dependencies; every other file of the block imports this package.
package smf_pkg;

  // Kernel and line geometry
  localparam int KERNEL_W  = 3;
  localparam int KERNEL_H  = 3;
  localparam int MAX_WIDTH = 1024;

  localparam int WIN_N   = KERNEL_W * KERNEL_H;
  localparam int MED_IDX = WIN_N / 2;
  localparam int RAD_W   = KERNEL_W / 2;
  localparam int RAD_H   = KERNEL_H / 2;

  // Field and counter widths
  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (CFG_W > WD_W) ? CFG_W : WD_W;
  localparam int ROW_W = CFG_W;
  localparam int LB_W  = (KERNEL_H - 1) * PIX_W;

  // Register port
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  typedef enum logic {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [PIX_W-1:0]                pix_t;
  typedef logic [KERNEL_H-1:0][PIX_W-1:0]  col_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0]     win_t;

  typedef struct packed {
    pix_t pixel_in;
    logic frame_start;
  } in_item_t;

  typedef struct packed {
    pix_t median_pixel;
    logic out_valid;
    logic out_last;
  } out_item_t;

  // Flags that travel with an item down the pipeline
  typedef struct packed {
    logic vld;
    logic out_valid;
    logic out_last;
    logic interior;
  } meta_t;

endpackage

>>> src/sliding_window_median_filter.sv
// Top level of the sliding-window median filter.
// Depends on smf_pkg, smf_line_buf, smf_col_cell and smf_sort_cell.
//
// Usage:
// - in_valid/in_stall/in_data take one grey pixel per item in raster order;
//   frame_start marks the first pixel of a frame.
// - Every accepted item gives one item on out_valid/out_stall/out_data: the
//   median of the window centred one radius up and left of the input pixel,
//   zero inside the border, with out_valid set when that position exists and
//   out_last on the frame's last pixel.
// - Throughput is one item per clock while out_stall does not hold the
//   pipeline. Each item passes the line store read, the window shift, one
//   register per sorter stage and the output register.
// - After reset the line store is swept to zero, one column a cycle, over all
//   MAX_WIDTH columns (1024); in_stall stays high meanwhile, register writes
//   are still taken.
// - When out_stall is high with a result waiting, the whole pipeline holds
//   and in_stall rises; nothing is dropped.
// - line_width (address 0) and frame_height (address 4) are written over the
//   APB-style port while the block is idle.
module sliding_window_median_filter
  import smf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0] line_width_r;
  logic [CFG_W-1:0] frame_height_r;
  reg_idx_t         reg_sel;

  logic             en;
  logic             acc;
  logic             clearing;

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic [CMP_W-1:0] lw_ext;
  logic [CMP_W-1:0] wd;
  logic [ROW_W-1:0] hg;
  logic [CMP_W-1:0] col_inc;
  logic             col_wrap;
  logic [ROW_W:0]   row_adv;
  meta_t            meta_cur;

  meta_t            s1_meta_r;
  pix_t             s1_pix_r;
  logic [COL_W-1:0] s1_addr_r;
  meta_t            s2_meta_r;

  logic [LB_W-1:0]  lb_rd;
  logic [LB_W-1:0]  lb_wr;
  logic             lb_we;
  col_t             new_col;
  col_t             cell_col [KERNEL_W];
  win_t             win;

  win_t             stg_vals [WIN_N];
  meta_t            stg_meta [WIN_N];

  logic             out_vld_r;
  out_item_t        out_data_r;

  // Register port
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_LINE_WIDTH:   line_width_r   <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[CFG_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LINE_WIDTH:   prdata = APB_DW'(line_width_r);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  // Pipeline advance and input handshake
  assign en       = !(out_vld_r && out_stall);
  assign in_stall = !en || clearing;
  assign acc      = in_valid && !in_stall;

  // Position of this pixel and of the next one
  always_comb begin
    lw_ext = CMP_W'(line_width_r);
    wd     = (lw_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : lw_ext;
    if (wd == '0) begin
      wd = CMP_W'(1);
    end
    hg       = (frame_height_r == '0) ? ROW_W'(1) : frame_height_r;
    col_cur  = in_data.frame_start ? '0 : col_r;
    row_cur  = in_data.frame_start ? '0 : row_r;
    col_inc  = CMP_W'(col_cur) + CMP_W'(1);
    col_wrap = (col_inc >= wd);
    col_nxt  = col_wrap ? '0 : col_inc[COL_W-1:0];
    row_adv  = {1'b0, row_cur} + (ROW_W+1)'(col_wrap);
    row_nxt  = (row_adv >= {1'b0, hg}) ? '0 : row_adv[ROW_W-1:0];

    meta_cur.vld       = acc;
    meta_cur.out_valid = (row_cur >= ROW_W'(RAD_H)) && (col_cur >= COL_W'(RAD_W));
    meta_cur.interior  = (row_cur >= ROW_W'(KERNEL_H - 1)) &&
                         (col_cur >= COL_W'(KERNEL_W - 1));
    meta_cur.out_last  = meta_cur.out_valid && (row_cur == hg - ROW_W'(1)) &&
                         (CMP_W'(col_cur) == wd - CMP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1: line store read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_meta_r <= '0;
    end else if (en) begin
      s1_meta_r <= meta_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r  <= in_data.pixel_in;
      s1_addr_r <= col_cur;
    end
  end

  smf_line_buf u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (acc),
    .rd_addr  (col_cur),
    .wr_en    (lb_we),
    .wr_addr  (s1_addr_r),
    .wr_data  (lb_wr),
    .rd_data  (lb_rd),
    .clearing (clearing)
  );

  // Push the new pixel into the column, oldest row drops out
  always_comb begin
    lb_we = en && s1_meta_r.vld;
    lb_wr = {lb_rd[LB_W-PIX_W-1:0], s1_pix_r};
    for (int i = 0; i < KERNEL_H - 1; i++) begin
      new_col[i] = lb_rd[(KERNEL_H - 2 - i) * PIX_W +: PIX_W];
    end
    new_col[KERNEL_H-1] = s1_pix_r;
  end

  // Window: chain of column cells, newest column at the end
  for (genvar j = 0; j < KERNEL_W; j++) begin : g_col
    if (j == KERNEL_W - 1) begin : g_head
      smf_col_cell u_cell (
        .clk    (clk),
        .shift  (lb_we),
        .col_in (new_col),
        .col_r  (cell_col[j])
      );
    end else begin : g_body
      smf_col_cell u_cell (
        .clk    (clk),
        .shift  (lb_we),
        .col_in (cell_col[j+1]),
        .col_r  (cell_col[j])
      );
    end
  end

  always_comb begin
    for (int i = 0; i < KERNEL_H; i++) begin
      for (int j = 0; j < KERNEL_W; j++) begin
        win[i*KERNEL_W + j] = cell_col[j][i];
      end
    end
  end

  // Stage 2: flags for the freshly shifted window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_meta_r <= '0;
    end else if (en) begin
      s2_meta_r <= s1_meta_r;
    end
  end

  // Sorter: one transposition stage per window element
  for (genvar s = 0; s < WIN_N; s++) begin : g_sort
    if (s == 0) begin : g_first
      smf_sort_cell u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .odd_phase (1'b0),
        .vals_in   (win),
        .meta_in   (s2_meta_r),
        .vals_r    (stg_vals[s]),
        .meta_r    (stg_meta[s])
      );
    end else begin : g_next
      smf_sort_cell u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .odd_phase (1'(s)),
        .vals_in   (stg_vals[s-1]),
        .meta_in   (stg_meta[s-1]),
        .vals_r    (stg_vals[s]),
        .meta_r    (stg_meta[s])
      );
    end
  end

  // Output register: take the middle element, zero at the border
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= stg_meta[WIN_N-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.median_pixel <= stg_meta[WIN_N-1].interior ?
                                 stg_vals[WIN_N-1][MED_IDX] : '0;
      out_data_r.out_valid    <= stg_meta[WIN_N-1].out_valid;
      out_data_r.out_last     <= stg_meta[WIN_N-1].out_last;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_frame_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.frame_start |=> !s1_meta_r.out_valid && !s1_meta_r.interior)
    else $error("frame start did not restart at the origin");

  a_interior_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s1_meta_r.vld && s1_meta_r.interior |-> s1_meta_r.out_valid)
    else $error("interior position flagged as not existing");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(stg_meta[WIN_N-1]) && $stable(s2_meta_r) && $stable(s1_meta_r))
    else $error("pipeline moved while output was stalled");

  a_last_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.out_last |-> out_data_r.out_valid)
    else $error("last flag on a position that does not exist");

endmodule

>>> src/smf_line_buf.sv
// Line store of the median filter: KERNEL_H-1 earlier rows packed per column.
// Depends on smf_pkg. Clears itself after reset, forwards a same-column write.
module smf_line_buf
  import smf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  logic [LB_W-1:0]  wr_data,
  output logic [LB_W-1:0]  rd_data,
  output logic             clearing
);

  logic [LB_W-1:0]  mem [MAX_WIDTH];
  logic [LB_W-1:0]  rd_q_r;
  logic             fwd_r;
  logic [LB_W-1:0]  fwd_data_r;
  logic             clr_active_r;
  logic [COL_W-1:0] clr_addr_r;
  logic             mem_we;
  logic [COL_W-1:0] mem_wa;
  logic [LB_W-1:0]  mem_wd;
  logic             clr_done;

  // Share the write port between the clearing sweep and item writes
  always_comb begin
    mem_we   = clr_active_r | wr_en;
    mem_wa   = clr_active_r ? clr_addr_r : wr_addr;
    mem_wd   = clr_active_r ? '0 : wr_data;
    clr_done = (clr_addr_r == COL_W'(MAX_WIDTH - 1));
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Catch a read of the column written at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  // Sweep every column to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_done) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign rd_data  = fwd_r ? fwd_data_r : rd_q_r;
  assign clearing = clr_active_r;

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !rd_en && !wr_en)
    else $error("line store accessed during clearing sweep");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r && clr_done |=> !clr_active_r)
    else $error("clearing sweep did not end at the last column");

  a_fwd_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    !rd_en |=> $stable(fwd_r))
    else $error("forward flag changed without a read");

endmodule

>>> src/smf_col_cell.sv
// One window column cell: holds KERNEL_H pixels and hands them to its neighbour.
// Depends on smf_pkg.
module smf_col_cell
  import smf_pkg::*;
(
  input  logic clk,
  input  logic shift,
  input  col_t col_in,
  output col_t col_r
);

  // Take the neighbour's column on each item
  always_ff @(posedge clk) begin
    if (shift) begin
      col_r <= col_in;
    end
  end

endmodule

>>> src/smf_sort_cell.sv
// One stage of the odd-even transposition sorter over the whole window.
// Depends on smf_pkg; WIN_N chained stages sort the window ascending.
module smf_sort_cell
  import smf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  odd_phase,
  input  win_t  vals_in,
  input  meta_t meta_in,
  output win_t  vals_r,
  output meta_t meta_r
);

  win_t vals_nxt;

  // Compare and exchange each pair of this phase, smaller value first
  always_comb begin
    vals_nxt = vals_in;
    for (int k = 0; k + 1 < WIN_N; k++) begin
      if ((1'(k) == odd_phase) && (vals_in[k] > vals_in[k+1])) begin
        vals_nxt[k]   = vals_in[k+1];
        vals_nxt[k+1] = vals_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vals_r <= vals_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r <= '0;
    end else if (en) begin
      meta_r <= meta_in;
    end
  end

endmodule
